// ===== sv/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants of the quaternion to rotation matrix unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrm_pkg;

	// matrix entries per result item
	localparam int N_ELEM = 9;
	// width of one matrix entry, signed Q2.14
	localparam int ELEM_W = 16;
	// quotient bits that can be set; the entry magnitude never exceeds 1.0
	localparam int QUO_W  = 15;
	// fraction bits of the numerator scale
	localparam int FRAC_SH = 15;
	// 1.0 in Q2.14
	localparam logic signed [ELEM_W-1:0] ONE_Q14 = 16'sd16384;

	// control bits that travel beside each item through the divider
	typedef struct packed {
		logic              valid;
		logic              zero;
		logic [N_ELEM-1:0] neg;
	} qrm_ctrl_t;

endpackage

// ===== sv/qrm_div_stage.sv =====
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine matrix entries: decides one
// quotient bit per entry and registers remainder, quotient and divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrm_div_stage import qrm_pkg::*; #(
	parameter int IN_WIDTH = 16,
	parameter int BIT      = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  qrm_ctrl_t                                ctrl_in,
	input  logic [2*IN_WIDTH+1:0]                    d_in,
	input  logic [N_ELEM-1:0][2*IN_WIDTH+15:0]       rem_in,
	input  logic [N_ELEM-1:0][QUO_W-1:0]             quo_in,
	output qrm_ctrl_t                                ctrl_out,
	output logic [2*IN_WIDTH+1:0]                    d_out,
	output logic [N_ELEM-1:0][2*IN_WIDTH+15:0]       rem_out,
	output logic [N_ELEM-1:0][QUO_W-1:0]             quo_out
);

	localparam int MW = 2*IN_WIDTH + 16;

	logic [MW-1:0]                  t;
	logic [N_ELEM-1:0][MW-1:0]      rem_nxt;
	logic [N_ELEM-1:0][QUO_W-1:0]   quo_nxt;

	assign t = MW'(d_in) << BIT;

	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			if (rem_in[i] >= t) begin
				rem_nxt[i] = rem_in[i] - t;
				quo_nxt[i] = quo_in[i] | (QUO_W'(1) << BIT);
			end else begin
				rem_nxt[i] = rem_in[i];
				quo_nxt[i] = quo_in[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else if (en) begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out   <= d_in;
			rem_out <= rem_nxt;
			quo_out <= quo_nxt;
		end
	end

endmodule

// ===== sv/quaternion_to_rotation_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Pipeline: products, sums, setup, fifteen division steps, output register.
// Throughput: one item per cycle; a skid stage at the output keeps s_tready
//   registered, so the pipeline stalls as a whole only while the skid is full.
// Reset: arst_n clears all valid bits and the output/skid registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_unit import qrm_pkg::*; #(
	parameter int IN_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// quat_w, quat_x, quat_y, quat_z (IN_WIDTH bits each), zero pad to bytes
	input  logic [((4*IN_WIDTH+7)/8)*8-1:0]        s_tdata,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// elem_0_0, elem_0_1, elem_0_2, elem_1_0, ... elem_2_2 (16 bits each)
	output logic [N_ELEM*ELEM_W-1:0]               m_tdata,
	// zero_quaternion
	output logic                                   m_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready
);

	localparam int W  = IN_WIDTH;
	localparam int PW = 2*W;        // product width
	localparam int SW = 2*W + 1;    // sum of squares
	localparam int NW = 2*W + 2;    // numerator, signed
	localparam int DW = 2*W + 2;    // divisor 2s
	localparam int AW = 2*W + 17;   // scaled numerator plus rounding, signed
	localparam int MW = 2*W + 16;   // dividend magnitude

	logic en;
	logic skid_valid_q;

	// ---------------- stage 1: products
	logic signed [W-1:0]  qw, qx, qy, qz;
	logic                 valid_s1;
	logic signed [PW-1:0] sq_w_s1, sq_x_s1, sq_y_s1, sq_z_s1;
	logic signed [PW-1:0] p_xy_s1, p_zw_s1, p_xz_s1, p_yw_s1, p_yz_s1, p_xw_s1;

	assign qw = s_tdata[W-1:0];
	assign qx = s_tdata[2*W-1:W];
	assign qy = s_tdata[3*W-1:2*W];
	assign qz = s_tdata[4*W-1:3*W];

	assign en       = !skid_valid_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_w_s1 <= qw * qw;
			sq_x_s1 <= qx * qx;
			sq_y_s1 <= qy * qy;
			sq_z_s1 <= qz * qz;
			p_xy_s1 <= qx * qy;
			p_zw_s1 <= qz * qw;
			p_xz_s1 <= qx * qz;
			p_yw_s1 <= qy * qw;
			p_yz_s1 <= qy * qz;
			p_xw_s1 <= qx * qw;
		end
	end

	// ---------------- stage 2: sum of squares and numerators
	logic                             valid_s2, zero_s2;
	logic [SW-1:0]                    s_s2;
	logic signed [N_ELEM-1:0][NW-1:0] num_s2;
	logic signed [NW-1:0]             s_sum;
	logic signed [N_ELEM-1:0][NW-1:0] num_nxt;

	always_comb begin
		s_sum = NW'(sq_w_s1) + NW'(sq_x_s1) + NW'(sq_y_s1) + NW'(sq_z_s1);
		num_nxt[0] = NW'(sq_x_s1) + NW'(sq_w_s1) - NW'(sq_y_s1) - NW'(sq_z_s1);
		num_nxt[1] = (NW'(p_xy_s1) - NW'(p_zw_s1)) <<< 1;
		num_nxt[2] = (NW'(p_xz_s1) + NW'(p_yw_s1)) <<< 1;
		num_nxt[3] = (NW'(p_xy_s1) + NW'(p_zw_s1)) <<< 1;
		num_nxt[4] = NW'(sq_y_s1) + NW'(sq_w_s1) - NW'(sq_x_s1) - NW'(sq_z_s1);
		num_nxt[5] = (NW'(p_yz_s1) - NW'(p_xw_s1)) <<< 1;
		num_nxt[6] = (NW'(p_xz_s1) - NW'(p_yw_s1)) <<< 1;
		num_nxt[7] = (NW'(p_yz_s1) + NW'(p_xw_s1)) <<< 1;
		num_nxt[8] = NW'(sq_z_s1) + NW'(sq_w_s1) - NW'(sq_x_s1) - NW'(sq_y_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= s_sum[SW-1:0];
			zero_s2 <= (s_sum == '0);
			num_s2  <= num_nxt;
		end
	end

	// ---------------- stage 3: rounding offset, sign split, divisor
	qrm_ctrl_t                    ctrl_s3;
	logic [DW-1:0]                d_s3;
	logic [N_ELEM-1:0][MW-1:0]    m_s3;
	logic signed [AW-1:0]         a_pos [N_ELEM];
	logic signed [AW-1:0]         a_neg [N_ELEM];
	logic [N_ELEM-1:0]            neg_nxt;
	logic [N_ELEM-1:0][MW-1:0]    m_nxt;

	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			// an element select of a packed array is unsigned: restore the sign
			a_pos[i]   = (AW'($signed(num_s2[i])) <<< FRAC_SH) +
				AW'($signed({1'b0, s_s2}));
			a_neg[i]   = AW'($signed({1'b0, s_s2, 1'b0})) - a_pos[i] - 1;
			neg_nxt[i] = a_pos[i][AW-1];
			m_nxt[i]   = neg_nxt[i] ? a_neg[i][MW-1:0] : a_pos[i][MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3.valid <= valid_s2;
			ctrl_s3.zero  <= zero_s2;
			ctrl_s3.neg   <= neg_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= {s_s2, 1'b0};
			m_s3 <= m_nxt;
		end
	end

	// ---------------- stages 4..18: one quotient bit per stage
	qrm_ctrl_t                     ctrl_c [QUO_W+1];
	logic [DW-1:0]                 d_c    [QUO_W+1];
	logic [N_ELEM-1:0][MW-1:0]     rem_c  [QUO_W+1];
	logic [N_ELEM-1:0][QUO_W-1:0]  quo_c  [QUO_W+1];

	assign ctrl_c[0] = ctrl_s3;
	assign d_c[0]    = d_s3;
	assign rem_c[0]  = m_s3;
	assign quo_c[0]  = '0;

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		qrm_div_stage #(
			.IN_WIDTH (IN_WIDTH),
			.BIT      (QUO_W - 1 - g)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_c[g]),
			.d_in     (d_c[g]),
			.rem_in   (rem_c[g]),
			.quo_in   (quo_c[g]),
			.ctrl_out (ctrl_c[g+1]),
			.d_out    (d_c[g+1]),
			.rem_out  (rem_c[g+1]),
			.quo_out  (quo_c[g+1])
		);
	end

	// ---------------- stage 19: sign, zero override, output skid
	qrm_ctrl_t                   ctrl_l;
	logic [N_ELEM*ELEM_W-1:0]    res_data;
	logic [ELEM_W-1:0]           mag;
	logic                        in_fire;
	logic                        out_valid_q;
	logic [N_ELEM*ELEM_W-1:0]    out_data_q, skid_data_q;
	logic                        out_user_q, skid_user_q;

	assign ctrl_l = ctrl_c[QUO_W];

	always_comb begin
		res_data = '0;
		mag      = '0;
		for (int i = 0; i < N_ELEM; i++) begin
			mag = {1'b0, quo_c[QUO_W][i]};
			if (ctrl_l.zero) begin
				res_data[i*ELEM_W +: ELEM_W] = (i == 0 || i == 4 || i == 8) ? ONE_Q14 : '0;
			end else if (ctrl_l.neg[i]) begin
				res_data[i*ELEM_W +: ELEM_W] = ELEM_W'(0) - mag;
			end else begin
				res_data[i*ELEM_W +: ELEM_W] = mag;
			end
		end
	end

	assign in_fire = ctrl_l.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= 1'b0;
			skid_data_q  <= '0;
			skid_user_q  <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				// drain the held item first
				out_valid_q  <= 1'b1;
				out_data_q   <= skid_data_q;
				out_user_q   <= skid_user_q;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
				out_data_q  <= res_data;
				out_user_q  <= ctrl_l.zero;
			end
		end else if (in_fire) begin
			// output held: park the arriving item
			skid_valid_q <= 1'b1;
			skid_data_q  <= res_data;
			skid_user_q  <= ctrl_l.zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// ---------------- assertions
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid filled although the output was free");

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[ELEM_W-1:0]) <= ONE_Q14 &&
			$signed(m_tdata[ELEM_W-1:0]) >= -ONE_Q14))
		else $error("diagonal entry beyond unit magnitude");

endmodule

// ===== tb/quaternion_to_rotation_matrix_unit_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit_test
// Streams quaternions into the unit and checks every matrix that comes back
// against an integer model of the rounded, normalized rotation entries.
// Each side idles at random, in phases that range from no idling at all to
// long gaps. The sender drains the pipeline between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_unit_test import qrm_pkg::*;;

	localparam int IN_WIDTH      = 16;
	localparam int TDATA_W       = ((4*IN_WIDTH+7)/8)*8;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_PRINTED   = 40;
	localparam int PHASE_ITEMS   = 275;
	localparam int N_PHASES      = 6;

	// the first member sits in the high bits, so w ends up lowest in tdata
	typedef struct packed {
		logic signed [IN_WIDTH-1:0] z;
		logic signed [IN_WIDTH-1:0] y;
		logic signed [IN_WIDTH-1:0] x;
		logic signed [IN_WIDTH-1:0] w;
	} quat_t;

	typedef struct packed {
		logic                          zero;
		logic [N_ELEM-1:0][ELEM_W-1:0] elem;
	} rot_matrix_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	// quat_w, quat_x, quat_y, quat_z
	logic [TDATA_W-1:0]        s_tdata = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// elem_0_0 .. elem_2_2
	logic [N_ELEM*ELEM_W-1:0]  m_tdata;
	// zero_quaternion
	logic                      m_tuser;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;

	quat_t       pending_quats[$];
	rot_matrix_t expected_matrices[$];
	int          send_gap = 0;
	int          recv_stall = 0;
	int          gap_max = 8;
	int          stall_max = 8;
	int          stall_draw;
	int          error_count = 0;
	int          cycle_count = 0;
	rot_matrix_t got_matrix;
	rot_matrix_t want_matrix;

	quaternion_to_rotation_matrix_unit #(
		.IN_WIDTH(IN_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	always #5 clk = ~clk;

	// floor(n/s * 16384 + 0.5), s > 0
	function automatic logic [ELEM_W-1:0] round_q14(longint n, longint s);
		longint num;
		longint den;
		longint q;
		num = n * 32768 + s;
		den = 2 * s;
		if (num >= 0)
			q = num / den;
		else
			q = -((-num + den - 1) / den);
		return q[ELEM_W-1:0];
	endfunction

	function automatic rot_matrix_t rotation_of(quat_t q);
		rot_matrix_t r;
		longint w, x, y, z, s;
		longint ww, xx, yy, zz;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		ww = w * w;
		xx = x * x;
		yy = y * y;
		zz = z * z;
		s = ww + xx + yy + zz;
		r = '0;
		if (s == 0) begin
			r.elem[0] = ONE_Q14;
			r.elem[4] = ONE_Q14;
			r.elem[8] = ONE_Q14;
			r.zero = 1'b1;
		end else begin
			r.elem[0] = round_q14((xx + ww) - (yy + zz), s);
			r.elem[1] = round_q14(2 * (x*y - z*w), s);
			r.elem[2] = round_q14(2 * (x*z + y*w), s);
			r.elem[3] = round_q14(2 * (x*y + z*w), s);
			r.elem[4] = round_q14((yy + ww) - (xx + zz), s);
			r.elem[5] = round_q14(2 * (y*z - x*w), s);
			r.elem[6] = round_q14(2 * (x*z - y*w), s);
			r.elem[7] = round_q14(2 * (y*z + x*w), s);
			r.elem[8] = round_q14((zz + ww) - (xx + yy), s);
		end
		return r;
	endfunction

	function automatic quat_t random_quat();
		int sel;
		logic signed [IN_WIDTH-1:0] comp[4];
		quat_t q;
		sel = $urandom_range(0, 99);
		for (int i = 0; i < 4; i++) begin
			if (sel < 50)
				comp[i] = IN_WIDTH'($urandom);
			else if (sel < 70)
				comp[i] = IN_WIDTH'($urandom_range(0, 8) - 4);
			else if (sel < 85)
				// sparse: some components zero
				comp[i] = ($urandom_range(0, 2) == 0) ? IN_WIDTH'($urandom) : '0;
			else if (sel < 97) begin
				case ($urandom_range(0, 4))
					0: comp[i] = IN_WIDTH'(-32768);
					1: comp[i] = IN_WIDTH'(32767);
					2: comp[i] = '0;
					3: comp[i] = IN_WIDTH'(-1);
					default: comp[i] = IN_WIDTH'(1);
				endcase
			end else
				comp[i] = '0;
		end
		q.w = comp[0];
		q.x = comp[1];
		q.y = comp[2];
		q.z = comp[3];
		return q;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_quats.size() != 0 || s_tvalid || expected_matrices.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_quat(int w, int x, int y, int z);
		quat_t q;
		q.w = IN_WIDTH'(w);
		q.x = IN_WIDTH'(x);
		q.y = IN_WIDTH'(y);
		q.z = IN_WIDTH'(z);
		pending_quats.insert(pending_quats.size(), q);
	endtask

	// sender: predict on accept, then load the next item once the gap has passed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_matrices.insert(expected_matrices.size(),
					rotation_of(quat_t'(s_tdata[4*IN_WIDTH-1:0])));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_quats.size() != 0) begin
					s_tdata <= TDATA_W'(pending_quats.pop_front());
					s_tvalid <= 1'b1;
					send_gap <= $urandom_range(0, gap_max);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each accepted matrix, then stall for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_matrices.size() == 0) begin
					report_mismatch("matrix arrived with none expected");
				end else begin
					want_matrix = expected_matrices.pop_front();
					got_matrix.elem = m_tdata;
					got_matrix.zero = m_tuser;
					for (int i = 0; i < N_ELEM; i++)
						if (got_matrix.elem[i] !== want_matrix.elem[i])
							report_mismatch($sformatf("elem_%0d_%0d: got %0d, want %0d",
								i / 3, i % 3, $signed(got_matrix.elem[i]),
								$signed(want_matrix.elem[i])));
					if (got_matrix.zero !== want_matrix.zero)
						report_mismatch($sformatf("zero_quaternion: got %b, want %b",
							got_matrix.zero, want_matrix.zero));
				end
				stall_draw = $urandom_range(0, stall_max);
				recv_stall <= stall_draw;
				m_tready <= (stall_draw == 0);
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				m_tready <= (recv_stall == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quaternion_to_rotation_matrix_unit regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all zero, single axes at both extremes, mixed extremes, tiny values
		push_quat(0, 0, 0, 0);
		push_quat(32767, 0, 0, 0);
		push_quat(0, 32767, 0, 0);
		push_quat(0, 0, 32767, 0);
		push_quat(0, 0, 0, 32767);
		push_quat(-32768, 0, 0, 0);
		push_quat(0, -32768, 0, 0);
		push_quat(0, 0, -32768, 0);
		push_quat(0, 0, 0, -32768);
		push_quat(-32768, -32768, -32768, -32768);
		push_quat(32767, 32767, 32767, 32767);
		push_quat(32767, -32768, 32767, -32768);
		push_quat(-32768, 32767, -1, 1);
		push_quat(1, 0, 0, 0);
		push_quat(0, 0, 0, -1);
		push_quat(-1, -1, -1, -1);
		push_quat(1, 1, 0, 0);
		push_quat(1, 2, 3, 4);
		push_quat(23170, 23170, 0, 0);
		push_quat(16384, 16384, 16384, 16384);
		push_quat(21845, -21846, 21845, -21846);
		push_quat(3, 0, 0, 4);
		push_quat(0, 1, -1, 0);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin gap_max = 8; stall_max = 8; end
				1: begin gap_max = 0; stall_max = 0; end
				2: begin gap_max = 0; stall_max = 8; end
				3: begin gap_max = 8; stall_max = 0; end
				4: begin gap_max = 3; stall_max = 3; end
				default: begin gap_max = 8; stall_max = 8; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_quats.insert(pending_quats.size(), random_quat());
			// hold the next phase back until every matrix is in
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("quaternion_to_rotation_matrix_unit regression: pass");
		else
			$display("quaternion_to_rotation_matrix_unit regression: fail");
		$finish;
	end

endmodule
